@@ hdl/cbpa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbpa_pkg: shared definitions for the block pool allocator
// Field widths, request and status codes, and the divider result bundle.
// ----------------------------------------------------------------------------
package cbpa_pkg;

    localparam int NUM_BLOCKS_DEF  = 256;
    localparam int BLOCK_BYTES_DEF = 64;

    localparam int ADDR_W  = 32;
    localparam int COUNT_W = 9;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic              done;
        logic              exact;
        logic [ADDR_W-1:0] quotient;
    } t_div_res;

endpackage

@@ hdl/cbpa_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbpa_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/cbpa_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbpa_div: block index from a pool offset
// Splits a byte offset into a block index by reciprocal multiplication through
// the r_off, r_prod and r_quo registers, and flags unaligned offsets.
// Offsets beyond the pool report an index of NUM_BLOCKS.
// ----------------------------------------------------------------------------
module cbpa_div #(
    parameter int NUM_BLOCKS  = cbpa_pkg::NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = cbpa_pkg::BLOCK_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cbpa_pkg::ADDR_W-1:0] i_dividend,
    output cbpa_pkg::t_div_res          o_res
);
    import cbpa_pkg::*;

    localparam int SPAN    = NUM_BLOCKS * BLOCK_BYTES;
    localparam int OFF_W   = $clog2(SPAN);
    localparam int FRAC_W  = $clog2(BLOCK_BYTES);
    localparam int SHIFT   = OFF_W + FRAC_W;
    localparam int RECIP_W = OFF_W + 1;
    localparam int PROD_W  = OFF_W + RECIP_W;
    localparam int QW      = $clog2(NUM_BLOCKS);
    localparam int QSAT_W  = $clog2(NUM_BLOCKS + 1);
    localparam longint RECIP_VAL =
        ((longint'(1) << SHIFT) / longint'(BLOCK_BYTES)) + longint'(1);
    localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(RECIP_VAL);
    localparam logic [ADDR_W-1:0]  SPAN_ADDR = ADDR_W'(SPAN);
    localparam logic [QSAT_W-1:0]  Q_OVER    = QSAT_W'(NUM_BLOCKS);
    localparam logic [OFF_W-1:0]   BB_OFF    = OFF_W'(BLOCK_BYTES);

    logic               r_v0, r_v1, r_v2;
    logic [ADDR_W-1:0]  r_off;
    logic               r_over;
    logic [PROD_W-1:0]  r_prod;
    logic [OFF_W-1:0]   r_low;
    logic [OFF_W-1:0]   r_low2;
    logic [QSAT_W-1:0]  r_quo;
    logic [OFF_W-1:0]   r_back;
    logic [QW-1:0]      quo_raw;
    logic [OFF_W-1:0]   back;

    assign quo_raw = r_prod[SHIFT +: QW];
    assign back    = OFF_W'(quo_raw) * BB_OFF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_start;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
        if (i_start) begin
            r_off <= i_dividend;
        end
        r_over <= (r_off >= SPAN_ADDR);
        r_prod <= PROD_W'(r_off[OFF_W-1:0]) * PROD_W'(RECIP);
        r_low  <= r_off[OFF_W-1:0];
        r_quo  <= r_over ? Q_OVER : QSAT_W'(quo_raw);
        r_back <= back;
        r_low2 <= r_low;
    end

    assign o_res.done     = r_v2;
    assign o_res.exact    = (r_back == r_low2);
    assign o_res.quotient = ADDR_W'(r_quo);

    property p_start_to_done;
        @(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##3 r_v2;
    endproperty
    a_start_to_done: assert property (p_start_to_done)
        else $error("divider did not finish in three cycles");

    property p_rem_below_divisor;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && (r_quo != Q_OVER)) |-> (r_back <= r_low2) && ((r_low2 - r_back) < BB_OFF);
    endproperty
    a_rem_below_divisor: assert property (p_rem_below_divisor)
        else $error("divider remainder out of range");

    property p_start_idle;
        @(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_v0 && !r_v1;
    endproperty
    a_start_idle: assert property (p_start_idle)
        else $error("divider restarted while in flight");

endmodule

@@ hdl/consecutive_block_pool_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// consecutive_block_pool_allocator: free-list allocator of consecutive blocks
// Allocates and frees runs of fixed-size blocks kept on a linked free list.
// ----------------------------------------------------------------------------
// A request (i_cmd, i_block_count, i_run_address) is taken when start is high
// and busy is low. Allocate walks the free list for a run of physically
// consecutive blocks; free divides the offset by the block size and links the
// run back after its physical predecessor or at the head of the list.
// Exactly one result per request appears on o_status and o_granted_address
// for one cycle with o_valid high; it cannot be held off.
// An allocate reads one link per step in S_A_RUN, for up to NUM_BLOCKS
// candidates times the block count, then passes S_A_MUL and S_A_OUT. A free
// turns the offset into a block index in the divider, walks the list through
// S_F_WALK and S_F_ADV (up to NUM_BLOCKS steps), relinks the predecessor in
// S_F_TAIL when it is found, and writes each freed block in S_F_CHAIN. The
// single read port of the link memory paces the walks. Busy drops in the
// cycle that carries the result, so the next request can be taken there.
// After reset the link memory is filled in address order, one entry per
// cycle, up to the last block; busy stays high meanwhile. pool_base may be
// written through i_cfg_we/i_cfg_wdata at any time the block is idle.
// ----------------------------------------------------------------------------
module consecutive_block_pool_allocator #(
    parameter int NUM_BLOCKS  = cbpa_pkg::NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = cbpa_pkg::BLOCK_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_cmd,
    input  logic [cbpa_pkg::COUNT_W-1:0] i_block_count,
    input  logic [cbpa_pkg::ADDR_W-1:0]  i_run_address,
    input  logic                         i_cfg_we,
    input  logic [cbpa_pkg::ADDR_W-1:0]  i_cfg_wdata,
    output logic                         o_valid,
    output logic                         o_status,
    output logic [cbpa_pkg::ADDR_W-1:0]  o_granted_address
);
    import cbpa_pkg::*;

    localparam int AW = $clog2(NUM_BLOCKS);
    localparam int LW = $clog2(NUM_BLOCKS + 1);
    localparam int CW = ((LW > COUNT_W) ? LW : COUNT_W) + 1;
    localparam logic [LW-1:0] NULL_LINK  = LW'(NUM_BLOCKS);
    localparam logic [LW-1:0] LAST_BLOCK = LW'(NUM_BLOCKS - 1);

    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_A_RUN   = 4'd2;
    localparam logic [3:0] S_A_MUL   = 4'd3;
    localparam logic [3:0] S_A_OUT   = 4'd4;
    localparam logic [3:0] S_F_DIV   = 4'd5;
    localparam logic [3:0] S_F_WALK  = 4'd6;
    localparam logic [3:0] S_F_ADV   = 4'd7;
    localparam logic [3:0] S_F_TAIL  = 4'd8;
    localparam logic [3:0] S_F_CHAIN = 4'd9;

    logic [3:0]         r_state, n_state;
    logic [LW-1:0]      r_head, n_head;
    logic [LW-1:0]      r_cur, n_cur;
    logic [LW-1:0]      r_prev, n_prev;
    logic [LW-1:0]      r_cur_next, n_cur_next;
    logic [LW-1:0]      r_steps, n_steps;
    logic [LW-1:0]      r_tail, n_tail;
    logic [AW-1:0]      r_start, n_start;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [COUNT_W-1:0] r_c, n_c;
    logic [COUNT_W-1:0] r_i, n_i;
    logic [ADDR_W-1:0]  r_pool_base;
    logic [ADDR_W-1:0]  r_prod, n_prod;
    logic               r_out_valid, n_out_valid;
    logic               r_out_status, n_out_status;
    logic [ADDR_W-1:0]  r_out_addr, n_out_addr;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [LW-1:0]      ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [LW-1:0]      ram_rdata;

    logic               accept;
    logic               div_start;
    t_div_res           div_res;

    logic [LW-1:0]      cur_next;
    logic [LW-1:0]      steps_inc;
    logic [CW-1:0]      cur_plus_c;
    logic               link_match;
    logic [ADDR_W:0]    run_end;
    logic [CW-1:0]      chain_pos;
    logic               chain_last;

    assign accept    = start && (r_state == S_IDLE);
    assign div_start = accept && (i_cmd == CMD_FREE) && (i_block_count != '0);

    cbpa_ram #(
        .WIDTH (LW),
        .DEPTH (NUM_BLOCKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    cbpa_div #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_run_address - r_pool_base),
        .o_res      (div_res)
    );

    assign cur_next   = (r_c == COUNT_W'(1)) ? ram_rdata : r_cur_next;
    assign steps_inc  = r_steps + 1'b1;
    assign cur_plus_c = CW'(r_cur) + CW'(r_c);
    assign link_match = (ram_rdata < NULL_LINK) && (CW'(ram_rdata) == cur_plus_c);
    assign run_end    = {1'b0, div_res.quotient} + (ADDR_W + 1)'(r_count);
    assign chain_pos  = CW'(r_start) + CW'(r_i);
    assign chain_last = (COUNT_W'(r_i + 1'b1) == r_count);

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_cur_next   = r_cur_next;
        n_steps      = r_steps;
        n_tail       = r_tail;
        n_start      = r_start;
        n_count      = r_count;
        n_c          = r_c;
        n_i          = r_i;
        n_prod       = r_prod;
        n_out_valid  = 1'b0;
        n_out_status = r_out_status;
        n_out_addr   = r_out_addr;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_raddr    = '0;

        case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_cur[AW-1:0];
                ram_wdata = r_cur + 1'b1;
                n_cur     = r_cur + 1'b1;
                if (r_cur == LAST_BLOCK) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_count = i_block_count;
                    if (i_cmd == CMD_ALLOC) begin
                        if ((i_block_count == '0) || (r_head >= NULL_LINK)) begin
                            n_out_valid  = 1'b1;
                            n_out_status = STATUS_FAIL;
                            n_out_addr   = '0;
                        end else begin
                            ram_raddr = r_head[AW-1:0];
                            n_cur     = r_head;
                            n_prev    = NULL_LINK;
                            n_steps   = '0;
                            n_c       = COUNT_W'(1);
                            n_state   = S_A_RUN;
                        end
                    end else begin
                        if (i_block_count == '0) begin
                            n_out_valid  = 1'b1;
                            n_out_status = STATUS_FAIL;
                            n_out_addr   = '0;
                        end else begin
                            n_state = S_F_DIV;
                        end
                    end
                end
            end
            S_A_RUN: begin
                n_cur_next = cur_next;
                if (r_c == r_count) begin
                    if (r_prev < NULL_LINK) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_prev[AW-1:0];
                        ram_wdata = ram_rdata;
                    end else begin
                        n_head = ram_rdata;
                    end
                    n_state = S_A_MUL;
                end else if (link_match) begin
                    ram_raddr = ram_rdata[AW-1:0];
                    n_c       = r_c + 1'b1;
                end else begin
                    n_prev  = r_cur;
                    n_cur   = cur_next;
                    n_steps = steps_inc;
                    if ((steps_inc < NULL_LINK) && (cur_next < NULL_LINK)) begin
                        ram_raddr = cur_next[AW-1:0];
                        n_c       = COUNT_W'(1);
                    end else begin
                        n_out_valid  = 1'b1;
                        n_out_status = STATUS_FAIL;
                        n_out_addr   = '0;
                        n_state      = S_IDLE;
                    end
                end
            end
            S_A_MUL: begin
                n_prod  = ADDR_W'(ADDR_W'(r_cur) * ADDR_W'(BLOCK_BYTES));
                n_state = S_A_OUT;
            end
            S_A_OUT: begin
                n_out_valid  = 1'b1;
                n_out_status = STATUS_OK;
                n_out_addr   = r_pool_base + r_prod;
                n_state      = S_IDLE;
            end
            S_F_DIV: begin
                if (div_res.done) begin
                    if (!div_res.exact || (run_end > (ADDR_W + 1)'(NUM_BLOCKS))) begin
                        n_out_valid  = 1'b1;
                        n_out_status = STATUS_FAIL;
                        n_out_addr   = '0;
                        n_state      = S_IDLE;
                    end else begin
                        n_start = div_res.quotient[AW-1:0];
                        n_i     = '0;
                        if (r_head >= NULL_LINK) begin
                            n_tail  = NULL_LINK;
                            n_head  = LW'(div_res.quotient[AW-1:0]);
                            n_state = S_F_CHAIN;
                        end else if (div_res.quotient[AW-1:0] == '0) begin
                            n_tail  = r_head;
                            n_head  = '0;
                            n_state = S_F_CHAIN;
                        end else begin
                            n_cur   = r_head;
                            n_steps = '0;
                            n_state = S_F_WALK;
                        end
                    end
                end
            end
            S_F_WALK: begin
                if ((r_steps >= NULL_LINK) || (r_cur >= NULL_LINK)) begin
                    n_tail  = r_head;
                    n_head  = LW'(r_start);
                    n_state = S_F_CHAIN;
                end else if ((CW'(r_cur) + CW'(1)) == CW'(r_start)) begin
                    ram_raddr = r_cur[AW-1:0];
                    n_state   = S_F_TAIL;
                end else begin
                    ram_raddr = r_cur[AW-1:0];
                    n_state   = S_F_ADV;
                end
            end
            S_F_ADV: begin
                n_cur   = ram_rdata;
                n_steps = steps_inc;
                n_state = S_F_WALK;
            end
            S_F_TAIL: begin
                n_tail    = ram_rdata;
                ram_we    = 1'b1;
                ram_waddr = r_cur[AW-1:0];
                ram_wdata = LW'(r_start);
                n_state   = S_F_CHAIN;
            end
            S_F_CHAIN: begin
                ram_we    = 1'b1;
                ram_waddr = chain_pos[AW-1:0];
                ram_wdata = chain_last ? r_tail : LW'(chain_pos + CW'(1));
                n_i       = r_i + 1'b1;
                if (chain_last) begin
                    n_out_valid  = 1'b1;
                    n_out_status = STATUS_OK;
                    n_out_addr   = '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_head      <= '0;
            r_cur       <= '0;
            r_pool_base <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_cur       <= n_cur;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_pool_base <= i_cfg_wdata;
            end
        end
        r_prev       <= n_prev;
        r_cur_next   <= n_cur_next;
        r_steps      <= n_steps;
        r_tail       <= n_tail;
        r_start      <= n_start;
        r_count      <= n_count;
        r_c          <= n_c;
        r_i          <= n_i;
        r_prod       <= n_prod;
        r_out_status <= n_out_status;
        r_out_addr   <= n_out_addr;
    end

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = r_out_valid;
    assign o_status          = r_out_status;
    assign o_granted_address = r_out_addr;

    property p_result_after_work;
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy) || $past(accept);
    endproperty
    a_result_after_work: assert property (p_result_after_work)
        else $error("result without a request in progress");

    property p_accept_progress;
        @(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy || o_valid;
    endproperty
    a_accept_progress: assert property (p_accept_progress)
        else $error("accepted request was dropped");

    property p_fail_zero_addr;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == STATUS_FAIL)) |-> (o_granted_address == '0);
    endproperty
    a_fail_zero_addr: assert property (p_fail_zero_addr)
        else $error("failed request returned an address");

    property p_head_in_range;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_head <= NULL_LINK;
    endproperty
    a_head_in_range: assert property (p_head_in_range)
        else $error("free list head out of range");

    property p_run_count;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_A_RUN) |-> (r_c != '0) && (r_c <= r_count);
    endproperty
    a_run_count: assert property (p_run_count)
        else $error("run length counter out of range");

endmodule
